// ----- rtl/pattern_slot_table_core_macros.svh -----
// Assertion macros for the pattern slot table core.
// Included by files that check their own logic; no other dependencies.
`ifndef PATTERN_SLOT_TABLE_CORE_MACROS_SVH
`define PATTERN_SLOT_TABLE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define PST_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pst: assertion failed");
`define PST_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pst: assertion failed");
`else
`define PST_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define PST_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/pst_pkg.sv -----
// Shared types, codes and defaults for the pattern slot table core.
// No dependencies.
package pst_pkg;

  localparam int SLOTS_DEF        = 128;
  localparam int PATTERN_BITS_DEF = 7;

  localparam logic [1:0] KIND_SCAN   = 2'd0;
  localparam logic [1:0] KIND_ENROLL = 2'd1;
  localparam logic [1:0] KIND_DELETE = 2'd2;

  localparam logic [2:0] ST_NO_FINGER = 3'd0;
  localparam logic [2:0] ST_NO_MATCH  = 3'd1;
  localparam logic [2:0] ST_MATCH     = 3'd2;
  localparam logic [2:0] ST_ENROLLED  = 3'd3;
  localparam logic [2:0] ST_SAME      = 3'd4;
  localparam logic [2:0] ST_DELETED   = 3'd5;
  localparam logic [2:0] ST_WAS_EMPTY = 3'd6;

  typedef struct packed {
    logic [1:0] kind;
    logic       finger_on;
    logic [6:0] pattern;
    logic [6:0] slot;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [6:0] match_slot;
  } out_item_t;

  typedef enum logic [2:0] {
    CS_CLEAR,
    CS_IDLE,
    CS_SCAN,
    CS_ACCESS,
    CS_CHECK
  } ctrl_state_t;

  typedef struct packed {
    logic       load;
    logic       cnt_clr;
    logic       cnt_inc;
    logic       addr_cnt;
    logic       rd_en;
    logic       wr_en;
    logic       wr_used;
    logic       res_set;
    logic [2:0] res_status;
  } pst_cmd_t;

  typedef struct packed {
    logic pend;
    logic pend_last;
    logic cnt_last;
    logic used;
    logic same;
  } pst_stat_t;

endpackage

// ----- rtl/pst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/pst_ctrl.sv -----
// Control FSM: clearing pass, request dispatch, scan walk, enroll/delete check.
// Depends on pst_pkg; drives pst_datapath through pst_cmd_t.
module pst_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_kind,
  input  logic               in_finger,
  input  pst_pkg::pst_stat_t stat,
  output pst_pkg::pst_cmd_t  cmd,
  output logic               busy
);
  import pst_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        enroll_r, enroll_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= CS_CLEAR;
      enroll_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      enroll_r <= enroll_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt  = state_r;
    enroll_nxt = enroll_r;
    case (state_r)
      CS_CLEAR: begin
        if (stat.cnt_last) state_nxt = CS_IDLE;
      end
      CS_IDLE: begin
        if (start) begin
          enroll_nxt = (in_kind == KIND_ENROLL);
          case (in_kind)
            KIND_SCAN:   if (in_finger) state_nxt = CS_SCAN;
            KIND_ENROLL: if (in_finger) state_nxt = CS_ACCESS;
            KIND_DELETE: state_nxt = CS_ACCESS;
            default:     state_nxt = CS_IDLE;
          endcase
        end
      end
      CS_SCAN: begin
        if (stat.pend && (stat.same || stat.pend_last)) state_nxt = CS_IDLE;
      end
      CS_ACCESS: state_nxt = CS_CHECK;
      CS_CHECK:  state_nxt = CS_IDLE;
      default:   state_nxt = CS_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    cmd  = '0;
    busy = (state_r != CS_IDLE);
    case (state_r)
      CS_CLEAR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_used  = 1'b0;
        cmd.addr_cnt = 1'b1;
        cmd.cnt_inc  = 1'b1;
      end
      CS_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          case (in_kind)
            KIND_SCAN: begin
              if (in_finger) begin
                cmd.cnt_clr = 1'b1;
              end else begin
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_NO_FINGER;
              end
            end
            KIND_ENROLL: begin
              if (!in_finger) begin
                cmd.res_set    = 1'b1;
                cmd.res_status = ST_NO_FINGER;
              end
            end
            default: cmd.load = 1'b1;
          endcase
        end
      end
      CS_SCAN: begin
        if (stat.pend && stat.same) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_MATCH;
        end else if (stat.pend && stat.pend_last) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_NO_MATCH;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.addr_cnt = 1'b1;
          cmd.cnt_inc  = 1'b1;
        end
      end
      CS_ACCESS: begin
        cmd.rd_en = 1'b1;
      end
      CS_CHECK: begin
        cmd.res_set = 1'b1;
        if (enroll_r) begin
          if (stat.same) begin
            cmd.res_status = ST_SAME;
          end else begin
            cmd.wr_en      = 1'b1;
            cmd.wr_used    = 1'b1;
            cmd.res_status = ST_ENROLLED;
          end
        end else begin
          if (!stat.used) begin
            cmd.res_status = ST_WAS_EMPTY;
          end else begin
            cmd.wr_en      = 1'b1;
            cmd.res_status = ST_DELETED;
          end
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

// ----- rtl/pst_datapath.sv -----
// Datapath: request registers, slot counter, slot RAM, compare and result register.
// Depends on pst_pkg and pst_ram; controlled by pst_ctrl.
module pst_datapath #(
  parameter int SLOTS        = pst_pkg::SLOTS_DEF,
  parameter int PATTERN_BITS = pst_pkg::PATTERN_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  pst_pkg::in_item_t   in_item,
  input  pst_pkg::pst_cmd_t   cmd,
  output pst_pkg::pst_stat_t  stat,
  output logic                out_valid,
  output pst_pkg::out_item_t  out_item
);
  import pst_pkg::*;

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int WORD_W = PATTERN_BITS + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic [PATTERN_BITS-1:0] req_pat_r;
  logic [IDX_W-1:0]        req_idx_r;
  logic [IDX_W-1:0]        slot_idx;
  logic [IDX_W-1:0]        cnt_r, cnt_nxt;
  logic                    pend_r;
  logic [IDX_W-1:0]        pend_addr_r;
  logic [IDX_W-1:0]        addr;
  logic [WORD_W-1:0]       wdata;
  logic [WORD_W-1:0]       rdata;
  logic                    out_valid_r;
  out_item_t               out_item_r;

  // slot number saturates at the top slot
  always_comb begin
    if (32'(in_item.slot) > 32'(SLOTS - 1)) begin
      slot_idx = LAST_IDX;
    end else begin
      slot_idx = IDX_W'(in_item.slot);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_clr) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_pat_r <= PATTERN_BITS'(in_item.pattern);
      req_idx_r <= slot_idx;
    end
    if (cmd.rd_en) begin
      pend_addr_r <= addr;
    end
    if (cmd.res_set) begin
      out_item_r.status     <= cmd.res_status;
      out_item_r.match_slot <= (cmd.res_status == ST_MATCH) ? 7'(pend_addr_r) : 7'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      pend_r      <= cmd.rd_en;
      out_valid_r <= cmd.res_set;
    end
  end

  assign addr  = cmd.addr_cnt ? cnt_r : req_idx_r;
  assign wdata = cmd.wr_used ? {1'b1, req_pat_r} : '0;

  pst_ram #(
    .WIDTH(WORD_W),
    .DEPTH(SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(addr),
    .wdata(wdata),
    .re   (cmd.rd_en),
    .raddr(addr),
    .rdata(rdata)
  );

  assign stat.pend      = pend_r;
  assign stat.pend_last = (pend_addr_r == LAST_IDX);
  assign stat.cnt_last  = (cnt_r == LAST_IDX);
  assign stat.used      = rdata[WORD_W-1];
  assign stat.same      = rdata[WORD_W-1] && (rdata[PATTERN_BITS-1:0] == req_pat_r);

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// ----- rtl/pattern_slot_table_core.sv -----
// Pattern slot table: a scan reads the slots in order and strobes on the first hit or after the last slot.
// Enroll/delete strobe after the ACCESS and CHECK states; no-finger scan/enroll requests strobe the next cycle.
// One item at a time: busy falls during the strobe cycle; a no-finger request never raises it.
// Scan time is set by the walk through the slot RAM, one read port, one slot per cycle.
// Reset (synchronous, active low) starts a clearing pass that writes every slot empty, with busy high.
// Results cannot be stalled. Depends on pst_pkg, pst_ctrl, pst_datapath, macros header.
`include "pattern_slot_table_core_macros.svh"
module pattern_slot_table_core #(
  parameter int SLOTS        = pst_pkg::SLOTS_DEF,
  parameter int PATTERN_BITS = pst_pkg::PATTERN_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  pst_pkg::in_item_t  in_item,
  output logic               out_valid,
  output pst_pkg::out_item_t out_item
);
  import pst_pkg::*;

  pst_cmd_t  cmd;
  pst_stat_t stat;

  pst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_kind  (in_item.kind),
    .in_finger(in_item.finger_on),
    .stat     (stat),
    .cmd      (cmd),
    .busy     (busy)
  );

  pst_datapath #(
    .SLOTS       (SLOTS),
    .PATTERN_BITS(PATTERN_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .stat     (stat),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  `PST_ASSERT_NXT(a_unused_kind_silent, clk, rst_n, start && !busy && in_item.kind != KIND_SCAN && in_item.kind != KIND_ENROLL && in_item.kind != KIND_DELETE, !out_valid)
  `PST_ASSERT_NXT(a_no_finger_fast, clk, rst_n, start && !busy && !in_item.finger_on && (in_item.kind == KIND_SCAN || in_item.kind == KIND_ENROLL), out_valid && out_item.status == ST_NO_FINGER)
  `PST_ASSERT_IMP(a_slot_only_on_match, clk, rst_n, out_valid && out_item.status != ST_MATCH, out_item.match_slot == 7'd0)
  `PST_ASSERT_IMP(a_write_while_busy, clk, rst_n, cmd.wr_en, busy)

endmodule
